// File: src/contiguous_message_coalescer_defines.svh
// Assertion macros for the contiguous message coalescer.
`ifndef CONTIGUOUS_MESSAGE_COALESCER_DEFINES_SVH
`define CONTIGUOUS_MESSAGE_COALESCER_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset
`define CMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock outside reset
`define CMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/cmc_pkg.sv
// Shared widths and record types for the contiguous message coalescer.
package cmc_pkg;

  localparam int LANE_W = 6;
  localparam int PE_W   = 16;
  localparam int ADDR_W = 64;
  localparam int SIZE_W = 32;
  localparam int TOT_W  = 38;
  localparam int CNT_W  = 7;

  // One lane request as held in the input register
  typedef struct packed {
    logic              lane_active;
    logic [PE_W-1:0]   target_pe;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [SIZE_W-1:0] msg_bytes;
    logic              wave_last;
  } lane_req_t;

  // One merged message waiting in the result queue
  typedef struct packed {
    logic [LANE_W-1:0] lead_lane;
    logic [PE_W-1:0]   pe;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [TOT_W-1:0]  total_bytes;
    logic [CNT_W-1:0]  lanes_merged;
    logic              wave_done;
    logic              item_last;
  } merged_msg_t;

endpackage

// File: src/contiguous_message_coalescer.sv
// Contiguous message coalescer top level: run tracking and result queue.
// Takes the lanes of a wavefront one request per cycle and merges runs of
// active lanes with the same PE and element size whose source and
// destination addresses advance by that size into single messages. A lane
// request is captured in an input register, compared from there against the
// open run and the previous lane's addresses (one 64-bit add and compare per
// address, plus a 38-bit running byte total), and the resulting messages are
// written into a four-entry result queue that drives the out_ ports.
// Throughput is one lane per cycle while the input side is not stalled. A lane
// that both breaks an open run and ends the wave produces two messages (old
// run first), which leave the queue one after the other; the input side
// stalls only while the queue holds more than two messages. Lane LANES-1 ends
// the wave even without in_wave_last.
`include "contiguous_message_coalescer_defines.svh"

module contiguous_message_coalescer #(
  parameter int LANES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // lane requests
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_lane_active,
  input  logic [cmc_pkg::PE_W-1:0]     in_target_pe,
  input  logic [cmc_pkg::ADDR_W-1:0]   in_src_addr,
  input  logic [cmc_pkg::ADDR_W-1:0]   in_dst_addr,
  input  logic [cmc_pkg::SIZE_W-1:0]   in_msg_bytes,
  input  logic                         in_wave_last,
  // merged messages
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cmc_pkg::LANE_W-1:0]   out_lead_lane,
  output logic [cmc_pkg::PE_W-1:0]     out_pe,
  output logic [cmc_pkg::ADDR_W-1:0]   out_src,
  output logic [cmc_pkg::ADDR_W-1:0]   out_dst,
  output logic [cmc_pkg::TOT_W-1:0]    out_total_bytes,
  output logic [cmc_pkg::CNT_W-1:0]    out_lanes_merged,
  output logic                         out_wave_done,
  output logic                         out_item_last
);
  import cmc_pkg::*;

  localparam int                DEPTH     = 4;
  localparam int                PTR_W     = $clog2(DEPTH);
  localparam int                QCNT_W    = PTR_W + 1;
  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(LANES - 1);

  // input register
  lane_req_t   req_r;
  logic        req_v_r;

  // run state
  logic              run_open_r,  run_open_nxt;
  logic [LANE_W-1:0] run_lead_r,  run_lead_nxt;
  logic [PE_W-1:0]   run_pe_r,    run_pe_nxt;
  logic [ADDR_W-1:0] run_src_r,   run_src_nxt;
  logic [ADDR_W-1:0] run_dst_r,   run_dst_nxt;
  logic [ADDR_W-1:0] prev_src_r,  prev_src_nxt;
  logic [ADDR_W-1:0] prev_dst_r,  prev_dst_nxt;
  logic [SIZE_W-1:0] run_elem_r,  run_elem_nxt;
  logic [CNT_W-1:0]  run_count_r, run_count_nxt;
  logic [TOT_W-1:0]  run_total_r, run_total_nxt;
  logic [LANE_W-1:0] lane_idx_r,  lane_idx_nxt;

  // result queue
  merged_msg_t       q_mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] q_cnt_r;

  logic        proc, pop, ends, joins, emit_old, emit_cur;
  logic [PTR_W-1:0] wr_ptr_second;
  merged_msg_t old_msg, cur_msg;

  // Process the held request once the queue has room for two messages
  assign proc     = req_v_r && (q_cnt_r <= QCNT_W'(DEPTH - 2));
  assign in_stall = req_v_r && !proc;
  assign out_valid = (q_cnt_r != '0);
  assign pop       = out_valid && !out_stall;

  // Compare the lane against the open run
  always_comb begin
    ends  = req_r.wave_last || (lane_idx_r >= LAST_LANE);
    joins = req_r.lane_active && run_open_r && (lane_idx_r != '0) &&
            (req_r.target_pe == run_pe_r) && (req_r.msg_bytes == run_elem_r) &&
            (req_r.src_addr == prev_src_r + ADDR_W'(req_r.msg_bytes)) &&
            (req_r.dst_addr == prev_dst_r + ADDR_W'(req_r.msg_bytes));
    emit_old = run_open_r && (!req_r.lane_active || !joins);
    emit_cur = req_r.lane_active && ends;
  end

  // Update the run state
  always_comb begin
    run_open_nxt  = run_open_r;
    run_lead_nxt  = run_lead_r;
    run_pe_nxt    = run_pe_r;
    run_src_nxt   = run_src_r;
    run_dst_nxt   = run_dst_r;
    prev_src_nxt  = prev_src_r;
    prev_dst_nxt  = prev_dst_r;
    run_elem_nxt  = run_elem_r;
    run_count_nxt = run_count_r;
    run_total_nxt = run_total_r;
    lane_idx_nxt  = lane_idx_r;
    if (proc) begin
      if (req_r.lane_active) begin
        if (joins) begin
          run_count_nxt = run_count_r + CNT_W'(1);
          run_total_nxt = run_total_r + TOT_W'(req_r.msg_bytes);
        end else begin
          run_open_nxt  = 1'b1;
          run_lead_nxt  = lane_idx_r;
          run_pe_nxt    = req_r.target_pe;
          run_src_nxt   = req_r.src_addr;
          run_dst_nxt   = req_r.dst_addr;
          run_elem_nxt  = req_r.msg_bytes;
          run_count_nxt = CNT_W'(1);
          run_total_nxt = TOT_W'(req_r.msg_bytes);
        end
        prev_src_nxt = req_r.src_addr;
        prev_dst_nxt = req_r.dst_addr;
        if (ends) begin
          run_open_nxt = 1'b0;
        end
      end else begin
        run_open_nxt = 1'b0;
      end
      lane_idx_nxt = ends ? '0 : lane_idx_r + LANE_W'(1);
    end
  end

  // Build the message for the run being closed and for the updated run
  always_comb begin
    old_msg.lead_lane    = run_lead_r;
    old_msg.pe           = run_pe_r;
    old_msg.src          = run_src_r;
    old_msg.dst          = run_dst_r;
    old_msg.total_bytes  = run_total_r;
    old_msg.lanes_merged = run_count_r;
    old_msg.wave_done    = req_r.lane_active ? 1'b0 : ends;
    old_msg.item_last    = req_r.lane_active ? !ends : 1'b1;

    cur_msg.lead_lane    = run_lead_nxt;
    cur_msg.pe           = run_pe_nxt;
    cur_msg.src          = run_src_nxt;
    cur_msg.dst          = run_dst_nxt;
    cur_msg.total_bytes  = run_total_nxt;
    cur_msg.lanes_merged = run_count_nxt;
    cur_msg.wave_done    = 1'b1;
    cur_msg.item_last    = 1'b1;

    wr_ptr_second = wr_ptr_r + PTR_W'(emit_old);
  end

  // Hold input request, run state and queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r    <= 1'b0;
      run_open_r <= 1'b0;
      lane_idx_r <= '0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      q_cnt_r    <= '0;
    end else begin
      if (!in_stall) begin
        req_v_r <= in_valid;
      end
      run_open_r <= run_open_nxt;
      lane_idx_r <= lane_idx_nxt;
      if (proc) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(emit_old) + PTR_W'(emit_cur);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      q_cnt_r <= q_cnt_r + (proc ? QCNT_W'(emit_old) + QCNT_W'(emit_cur) : '0)
                 - QCNT_W'(pop);
    end
  end

  // Capture payload of accepted requests and the run record
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r.lane_active <= in_lane_active;
      req_r.target_pe   <= in_target_pe;
      req_r.src_addr    <= in_src_addr;
      req_r.dst_addr    <= in_dst_addr;
      req_r.msg_bytes   <= in_msg_bytes;
      req_r.wave_last   <= in_wave_last;
    end
    run_lead_r  <= run_lead_nxt;
    run_pe_r    <= run_pe_nxt;
    run_src_r   <= run_src_nxt;
    run_dst_r   <= run_dst_nxt;
    prev_src_r  <= prev_src_nxt;
    prev_dst_r  <= prev_dst_nxt;
    run_elem_r  <= run_elem_nxt;
    run_count_r <= run_count_nxt;
    run_total_r <= run_total_nxt;
  end

  // Write up to two messages into the queue, old run first
  always_ff @(posedge clk) begin
    if (proc && emit_old) begin
      q_mem[wr_ptr_r] <= old_msg;
    end
    if (proc && emit_cur) begin
      q_mem[wr_ptr_second] <= cur_msg;
    end
  end

  // Drive the head of the queue
  assign out_lead_lane    = q_mem[rd_ptr_r].lead_lane;
  assign out_pe           = q_mem[rd_ptr_r].pe;
  assign out_src          = q_mem[rd_ptr_r].src;
  assign out_dst          = q_mem[rd_ptr_r].dst;
  assign out_total_bytes  = q_mem[rd_ptr_r].total_bytes;
  assign out_lanes_merged = q_mem[rd_ptr_r].lanes_merged;
  assign out_wave_done    = q_mem[rd_ptr_r].wave_done;
  assign out_item_last    = q_mem[rd_ptr_r].item_last;

  `CMC_ASSERT_IMP(a_queue_bound, 1'b1, q_cnt_r <= QCNT_W'(DEPTH), "result queue overflow")
  `CMC_ASSERT_NXT(a_wave_restart, proc && ends, (lane_idx_r == '0) && !run_open_r, "lane index not restarted after wave end")
  `CMC_ASSERT_IMP(a_run_count, run_open_r, (run_count_r != '0) && (run_count_r <= CNT_W'(LANES)), "open run has bad lane count")
  `CMC_ASSERT_IMP(a_done_last, out_valid && out_wave_done, out_item_last, "wave end message not last of its request")

endmodule

// File: test/contiguous_message_coalescer_tb.sv
// Self-checking testbench for the contiguous message coalescer: directed and random wavefronts.
`timescale 1ns / 100ps

module contiguous_message_coalescer_tb;
  import cmc_pkg::*;

  localparam int LANES       = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000;
  localparam int REQ_TARGET  = 1100;
  localparam int REPORT_MAX  = 10;
  localparam int DRAIN_WAIT  = 10;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_lane_active;
  logic [PE_W-1:0]   in_target_pe;
  logic [ADDR_W-1:0] in_src_addr;
  logic [ADDR_W-1:0] in_dst_addr;
  logic [SIZE_W-1:0] in_msg_bytes;
  logic              in_wave_last;
  logic              out_valid;
  logic              out_stall;
  logic [LANE_W-1:0] out_lead_lane;
  logic [PE_W-1:0]   out_pe;
  logic [ADDR_W-1:0] out_src;
  logic [ADDR_W-1:0] out_dst;
  logic [TOT_W-1:0]  out_total_bytes;
  logic [CNT_W-1:0]  out_lanes_merged;
  logic              out_wave_done;
  logic              out_item_last;

  // Predicted coalescer state
  logic              run_live;
  logic [LANE_W-1:0] run_first_lane;
  logic [PE_W-1:0]   run_target;
  logic [ADDR_W-1:0] run_src_base;
  logic [ADDR_W-1:0] run_dst_base;
  logic [ADDR_W-1:0] last_src;
  logic [ADDR_W-1:0] last_dst;
  logic [SIZE_W-1:0] run_elem;
  logic [CNT_W-1:0]  run_lanes;
  logic [LANE_W-1:0] lane_pos;
  merged_msg_t       expected_msgs[$];

  // Run control and bookkeeping
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int reqs_sent      = 0;
  int msgs_checked   = 0;
  int waves_ended    = 0;
  int split_reqs     = 0;
  int fail_count     = 0;
  int report_count   = 0;
  int quiet_cycles   = 0;

  contiguous_message_coalescer #(
    .LANES(LANES)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_lane_active   (in_lane_active),
    .in_target_pe     (in_target_pe),
    .in_src_addr      (in_src_addr),
    .in_dst_addr      (in_dst_addr),
    .in_msg_bytes     (in_msg_bytes),
    .in_wave_last     (in_wave_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_lead_lane    (out_lead_lane),
    .out_pe           (out_pe),
    .out_src          (out_src),
    .out_dst          (out_dst),
    .out_total_bytes  (out_total_bytes),
    .out_lanes_merged (out_lanes_merged),
    .out_wave_done    (out_wave_done),
    .out_item_last    (out_item_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // Close the open run into one expected message
  function automatic void queue_run(input logic done, input logic last);
    merged_msg_t m;
    m.lead_lane    = run_first_lane;
    m.pe           = run_target;
    m.src          = run_src_base;
    m.dst          = run_dst_base;
    m.total_bytes  = TOT_W'(run_elem) * TOT_W'(run_lanes);
    m.lanes_merged = run_lanes;
    m.wave_done    = done;
    m.item_last    = last;
    expected_msgs.push_back(m);
  endfunction

  // Advance the predicted state by one accepted lane request
  function automatic void coalesce_lane(input lane_req_t r);
    logic ends;
    logic joins;
    int   queued_on_entry;
    queued_on_entry = expected_msgs.size();
    ends   = r.wave_last || (lane_pos == LANES - 1);
    if (r.lane_active) begin
      joins = run_live && lane_pos != 0 && r.target_pe == run_target &&
              r.msg_bytes == run_elem &&
              r.src_addr == last_src + ADDR_W'(r.msg_bytes) &&
              r.dst_addr == last_dst + ADDR_W'(r.msg_bytes);
      if (joins) begin
        run_lanes = run_lanes + 1'b1;
      end else begin
        if (run_live) queue_run(1'b0, !ends);
        run_live       = 1'b1;
        run_first_lane = lane_pos;
        run_target     = r.target_pe;
        run_src_base   = r.src_addr;
        run_dst_base   = r.dst_addr;
        run_elem       = r.msg_bytes;
        run_lanes      = CNT_W'(1);
      end
      last_src = r.src_addr;
      last_dst = r.dst_addr;
      if (ends) begin
        queue_run(1'b1, 1'b1);
        run_live = 1'b0;
      end
    end else if (run_live) begin
      queue_run(ends, 1'b1);
      run_live = 1'b0;
    end
    if (expected_msgs.size() - queued_on_entry == 2) split_reqs++;
    if (ends) begin
      lane_pos = '0;
      waves_ended++;
    end else begin
      lane_pos = lane_pos + 1'b1;
    end
  endfunction

  // Offer one lane request and hold it until the block takes it
  task automatic send_lane(input lane_req_t r);
    int gap;
    gap = pick_gap(send_gap_pct);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_lane_active <= r.lane_active;
    in_target_pe   <= r.target_pe;
    in_src_addr    <= r.src_addr;
    in_dst_addr    <= r.dst_addr;
    in_msg_bytes   <= r.msg_bytes;
    in_wave_last   <= r.wave_last;
    do @(posedge clk); while (in_stall !== 1'b0);
    coalesce_lane(r);
    reqs_sent++;
  endtask

  function automatic lane_req_t make_lane(input bit act, input logic [PE_W-1:0] pe,
                                          input logic [ADDR_W-1:0] src,
                                          input logic [ADDR_W-1:0] dst,
                                          input logic [SIZE_W-1:0] size, input bit last);
    lane_req_t r;
    r.lane_active = act;
    r.target_pe   = pe;
    r.src_addr    = src;
    r.dst_addr    = dst;
    r.msg_bytes   = size;
    r.wave_last   = last;
    return r;
  endfunction

  // Random lane: few PEs so runs recur, sizes biased small, some addresses near the top
  function automatic lane_req_t random_lane();
    lane_req_t r;
    r.lane_active = 1'b1;
    r.target_pe   = ($urandom_range(0, 3) != 0) ? PE_W'($urandom_range(0, 3)) : PE_W'($urandom);
    r.src_addr    = {$urandom, $urandom};
    r.dst_addr    = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       r.msg_bytes = '0;
      1:       r.msg_bytes = '1;
      2, 3:    r.msg_bytes = $urandom;
      default: r.msg_bytes = SIZE_W'($urandom_range(1, 16));
    endcase
    if ($urandom_range(0, 7) == 0) r.src_addr[ADDR_W-1:8] = '1;
    if ($urandom_range(0, 7) == 0) r.dst_addr[ADDR_W-1:8] = '1;
    r.wave_last = 1'b0;
    return r;
  endfunction

  // Send one wavefront, mostly contiguous runs with breaks and inactive lanes
  task automatic run_wave(input int len, input bit mark_end);
    lane_req_t r;
    lane_req_t prev;
    prev = random_lane();
    for (int k = 0; k < len; k++) begin
      r = random_lane();
      if ($urandom_range(0, 99) < 12) begin
        r.lane_active = 1'b0;
      end else if (k > 0 && $urandom_range(0, 99) < 75) begin
        r.target_pe = prev.target_pe;
        r.msg_bytes = prev.msg_bytes;
        r.src_addr  = prev.src_addr + ADDR_W'(prev.msg_bytes);
        r.dst_addr  = prev.dst_addr + ADDR_W'(prev.msg_bytes);
        // spoil one field now and then to break the run
        case ($urandom_range(0, 11))
          0:       r.src_addr ^= ADDR_W'(1) << $urandom_range(0, ADDR_W - 1);
          1:       r.dst_addr ^= ADDR_W'(1) << $urandom_range(0, ADDR_W - 1);
          2:       r.target_pe ^= PE_W'(1) << $urandom_range(0, PE_W - 1);
          3:       r.msg_bytes = r.msg_bytes + 1'b1;
          default: ;
        endcase
      end
      r.wave_last = (mark_end && k == len - 1) || ($urandom_range(0, 199) == 0);
      send_lane(r);
      prev = r;
    end
  endtask

  // Wrap, zero size, full-width size, double message, wave end on an idle lane
  task automatic test_directed();
    send_gap_pct   = 20;
    recv_stall_pct = 20;
    send_lane(make_lane(1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE, 1, 0));
    send_lane(make_lane(1, '1, '0, '1, 1, 0));
    send_lane(make_lane(1, '1, 1, '0, 1, 0));
    send_lane(make_lane(1, '1, 1, '0, 0, 0));
    send_lane(make_lane(1, '1, 1, '0, 0, 0));
    send_lane(make_lane(0, '1, '1, '1, '1, 0));
    send_lane(make_lane(0, '0, '0, '0, '0, 1));
    send_lane(make_lane(1, '0, '0, '0, '1, 0));
    send_lane(make_lane(1, '0, 64'hFFFF_FFFF, 64'hFFFF_FFFF, '1, 0));
    send_lane(make_lane(1, 1, 64'h1000, 64'h2000, '1, 0));
    send_lane(make_lane(1, 1, 64'h5000, 64'h6000, 16, 1));
    send_lane(make_lane(1, 5, 64'h100, 64'h200, 8, 0));
    send_lane(make_lane(1, 5, 64'h108, 64'h209, 8, 0));
    send_lane(make_lane(1, 5, 64'h110, 64'h211, 8, 1));
    send_lane(make_lane(1, 7, 64'hA000, 64'hB000, 4, 0));
    send_lane(make_lane(0, 7, 64'hA004, 64'hB004, 4, 1));
    send_lane(make_lane(1, 16'h8000, 64'h8000_0000_0000_0000, 64'h1, 32'h8000_0000, 1));
  endtask

  // Fill a whole wave with one run so lane 63 closes it without a wave-last flag
  task automatic test_full_wave();
    lane_req_t r;
    r = random_lane();
    r.msg_bytes = '1;
    for (int k = 0; k < LANES; k++) begin
      send_lane(r);
      r.src_addr = r.src_addr + ADDR_W'(r.msg_bytes);
      r.dst_addr = r.dst_addr + ADDR_W'(r.msg_bytes);
    end
  endtask

  // Hold the output side while lanes keep coming, so the block stalls its input
  task automatic test_backpressure();
    lane_req_t r;
    send_gap_pct = 0;
    hold_req     = 1'b1;
    for (int k = 0; k < 40; k++) begin
      r = random_lane();
      r.target_pe = PE_W'(k);
      r.wave_last = (k == 39);
      send_lane(r);
    end
    wait (!hold_req);
  endtask

  // Random wavefronts under changing idle mixes, including stretches with none
  task automatic test_random_waves();
    while (reqs_sent < REQ_TARGET) begin
      case ($urandom_range(0, 3))
        0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_gap_pct = 30; recv_stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  recv_stall_pct = 50; end
        default: begin send_gap_pct = 35; recv_stall_pct = 35; end
      endcase
      if ($urandom_range(0, 9) == 0) run_wave(LANES, $urandom_range(0, 1));
      else run_wave($urandom_range(1, 16), 1'b1);
    end
  endtask

  // Output side: random stalls, plus one long hold on request
  initial begin : receiver
    int span;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        span = pick_gap(recv_stall_pct);
        if (span > 0) begin
          out_stall <= 1'b1;
          repeat (span - 1) @(negedge clk);
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Compare each accepted message with the oldest expected one
  always @(posedge clk) begin : result_check
    merged_msg_t got;
    merged_msg_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {out_lead_lane, out_pe, out_src, out_dst, out_total_bytes, out_lanes_merged,
             out_wave_done, out_item_last};
      if (expected_msgs.size() == 0) begin
        fail_count++;
        if (report_count < REPORT_MAX)
          $display("%0t: unexpected message lead %0d pe %h", $realtime, out_lead_lane, out_pe);
        report_count++;
      end else begin
        want = expected_msgs.pop_front();
        msgs_checked++;
        if (got !== want) begin
          fail_count++;
          if (report_count < REPORT_MAX) begin
            $display("%0t: message mismatch", $realtime);
            $display("  expected lead %0d pe %h src %h dst %h bytes %h lanes %0d done %b last %b",
                     want.lead_lane, want.pe, want.src, want.dst, want.total_bytes,
                     want.lanes_merged, want.wave_done, want.item_last);
            $display("  actual   lead %0d pe %h src %h dst %h bytes %h lanes %0d done %b last %b",
                     got.lead_lane, got.pe, got.src, got.dst, got.total_bytes,
                     got.lanes_merged, got.wave_done, got.item_last);
          end
          report_count++;
        end
      end
    end
  end

  // End the run if neither side moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : main_seq
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_lane_active = 1'b0;
    in_target_pe   = '0;
    in_src_addr    = '0;
    in_dst_addr    = '0;
    in_msg_bytes   = '0;
    in_wave_last   = 1'b0;
    run_live       = 1'b0;
    run_first_lane = '0;
    run_target     = '0;
    run_src_base   = '0;
    run_dst_base   = '0;
    last_src       = '0;
    last_dst       = '0;
    run_elem       = '0;
    run_lanes      = '0;
    lane_pos       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_wave();
    test_backpressure();
    test_random_waves();

    // drop valid, then let the last messages drain
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_msgs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    fail_count += expected_msgs.size();

    $display("%0d lane requests over %0d waves, %0d merged messages checked, %0d split twice",
             reqs_sent, waves_ended, msgs_checked, split_reqs);
    $display("covered address wrap, zero and full-width sizes, lane 63 wave end, %0d-cycle hold",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
